@@ rtl/ftpt_pkg.sv @@
`default_nettype none
package ftpt_pkg;

    localparam int TaskSlotsDef = 16;

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_REG    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [2:0] TYPE_INFO  = 3'd1;
    localparam logic [2:0] TYPE_CHUNK = 3'd2;
    localparam logic [2:0] TYPE_END   = 3'd3;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic read;
        logic update;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/file_transfer_progress_tracker.sv @@
`default_nettype none
// channel | handshake          | payload
// input   | i_valid / o_ready  | i_cmd .. i_pkt_file_size
// output  | o_valid / i_ready  | o_delivered .. o_out_of_order_count
//
// an item runs through read, update, div and out before idle takes the next; div waits
// only for a division, where the serial divider resolves one quotient bit per cycle over 64 bits.
// reset clears slot flags at once; table rows are zeroed on register of an inactive slot and on remove.
// a stalled output holds the next result in the last state until taken.
module file_transfer_progress_tracker
    import ftpt_pkg::*;
#(
    parameter int TASK_SLOTS = TaskSlotsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_task_slot,
    input  wire logic        i_is_control,
    input  wire logic [2:0]  i_pkt_type,
    input  wire logic [31:0] i_seq_num,
    input  wire logic [47:0] i_data_offset,
    input  wire logic [15:0] i_payload_bytes,
    input  wire logic [47:0] i_pkt_file_size,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_delivered,
    output logic [2:0]       o_event_type,
    output logic [47:0]      o_event_file_size,
    output logic [47:0]      o_received_bytes,
    output logic             o_completed,
    output logic [16:0]      o_progress,
    output logic [47:0]      o_event_offset,
    output logic [31:0]      o_event_seq,
    output logic [31:0]      o_packet_count,
    output logic [47:0]      o_byte_count,
    output logic [31:0]      o_duplicate_count,
    output logic [31:0]      o_out_of_order_count
);

    t_cmd    w_cmd;
    t_status w_status;

    ftpt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    ftpt_datapath #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_cmd_code           (i_cmd),
        .i_task_slot          (i_task_slot),
        .i_is_control         (i_is_control),
        .i_pkt_type           (i_pkt_type),
        .i_seq_num            (i_seq_num),
        .i_data_offset        (i_data_offset),
        .i_payload_bytes      (i_payload_bytes),
        .i_pkt_file_size      (i_pkt_file_size),
        .o_delivered          (o_delivered),
        .o_event_type         (o_event_type),
        .o_event_file_size    (o_event_file_size),
        .o_received_bytes     (o_received_bytes),
        .o_completed          (o_completed),
        .o_progress           (o_progress),
        .o_event_offset       (o_event_offset),
        .o_event_seq          (o_event_seq),
        .o_packet_count       (o_packet_count),
        .o_byte_count         (o_byte_count),
        .o_duplicate_count    (o_duplicate_count),
        .o_out_of_order_count (o_out_of_order_count)
    );

endmodule
`default_nettype wire

@@ rtl/ftpt_ctrl.sv @@
`default_nettype none
module ftpt_ctrl
    import ftpt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_ready     = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update    = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (!i_status.need_div || i_status.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // output register must be free before the next result lands
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_state == ST_READ) else $error("accept lost");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_valid) else $error("result not shown");
`endif

endmodule
`default_nettype wire

@@ rtl/ftpt_div.sv @@
`default_nettype none
module ftpt_div
    import ftpt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_num,
    input  wire logic [47:0] i_den,
    output logic             o_done,
    output logic [16:0]      o_quot
);

    // restoring divider on (num << 16) / den, one quotient bit per cycle
    logic [63:0] r_num;
    logic [48:0] r_rem;
    logic [63:0] r_quot;
    logic [47:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [48:0] w_shift;
    logic [49:0] w_diff;

    assign w_shift = {r_rem[47:0], r_num[63]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_num  <= {i_num, 16'h0};
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                if (!w_diff[49]) begin
                    r_rem  <= w_diff[48:0];
                    r_quot <= {r_quot[62:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    r_quot <= {r_quot[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_quot > {47'h0, ONE_Q16}) ? ONE_Q16 : r_quot[16:0];

endmodule
`default_nettype wire

@@ rtl/ftpt_datapath.sv @@
`default_nettype none
module ftpt_datapath
    import ftpt_pkg::*;
#(
    parameter int TASK_SLOTS = TaskSlotsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic [1:0]  i_cmd_code,
    input  wire logic [3:0]  i_task_slot,
    input  wire logic        i_is_control,
    input  wire logic [2:0]  i_pkt_type,
    input  wire logic [31:0] i_seq_num,
    input  wire logic [47:0] i_data_offset,
    input  wire logic [15:0] i_payload_bytes,
    input  wire logic [47:0] i_pkt_file_size,
    output logic             o_delivered,
    output logic [2:0]       o_event_type,
    output logic [47:0]      o_event_file_size,
    output logic [47:0]      o_received_bytes,
    output logic             o_completed,
    output logic [16:0]      o_progress,
    output logic [47:0]      o_event_offset,
    output logic [31:0]      o_event_seq,
    output logic [31:0]      o_packet_count,
    output logic [47:0]      o_byte_count,
    output logic [31:0]      o_duplicate_count,
    output logic [31:0]      o_out_of_order_count
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    // slot table, one row per slot
    logic [47:0] m_fsize [TASK_SLOTS];
    logic [47:0] m_mark  [TASK_SLOTS];
    logic [31:0] m_prev  [TASK_SLOTS];
    logic [31:0] m_pkts  [TASK_SLOTS];
    logic [47:0] m_bytes [TASK_SLOTS];
    logic [31:0] m_dup   [TASK_SLOTS];
    logic [31:0] m_late  [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] r_active, r_done_f, r_seen;

    logic [1:0]  r_cmd;
    logic [3:0]  r_slot;
    logic        r_ctrl;
    logic [2:0]  r_type;
    logic [31:0] r_seq;
    logic [47:0] r_off, r_fsz;
    logic [15:0] r_len;

    logic [47:0] r_t_fsize, r_t_mark, r_t_bytes;
    logic [31:0] r_t_prev, r_t_pkts, r_t_dup, r_t_late;
    logic        r_t_done, r_t_seen, r_t_act;

    // result of the update
    logic        r_deliv, r_comp;
    logic [47:0] r_evsize, r_recv, r_bcnt;
    logic [31:0] r_pcnt, r_dcnt, r_lcnt;

    logic        w_inrange;
    logic [SW-1:0] w_idx;
    logic [48:0] w_end_sum;
    logic [47:0] w_end;
    logic [47:0] n_fsize, n_mark, n_bytes;
    logic [31:0] n_pkts, n_dup, n_late;
    logic        n_done, n_seen;
    logic        w_event;
    logic [47:0] n_evsize, n_recv;
    logic        n_comp;
    logic        w_div_done;
    logic [16:0] w_quot;

    assign w_inrange = {28'h0, r_slot} < TASK_SLOTS;
    assign w_idx     = SW'(r_slot);
    assign w_end_sum = {1'b0, r_off} + {33'h0, r_len};
    assign w_end     = w_end_sum[48] ? MAX48 : w_end_sum[47:0];
    assign w_event   = r_cmd == CMD_PACKET && w_inrange && r_t_act;

    always_comb begin
        n_pkts  = r_t_pkts + 32'd1;
        n_bytes = r_t_bytes + {32'h0, r_len};
        n_fsize = (r_fsz != '0) ? r_fsz : r_t_fsize;
        n_mark  = r_t_mark;
        n_done  = r_t_done;
        n_seen  = r_t_seen;
        n_dup   = r_t_dup;
        n_late  = r_t_late;
        if (r_type == TYPE_INFO) begin
            n_mark = '0;
            n_done = 1'b0;
            n_seen = 1'b0;
        end else if (r_type == TYPE_CHUNK || r_type == TYPE_END) begin
            if (w_end > n_mark) begin
                n_mark = w_end;
            end
            if (r_type == TYPE_END) begin
                if (n_fsize != '0) begin
                    n_mark = n_fsize;
                end
                n_done = 1'b1;
            end
        end
        if (n_seen) begin
            if (r_seq == r_t_prev) begin
                n_dup = r_t_dup + 32'd1;
            end else if (r_seq < r_t_prev) begin
                n_late = r_t_late + 32'd1;
            end
        end
        if (r_ctrl) begin
            n_evsize = r_fsz;
            n_recv   = w_end;
            n_comp   = r_type == TYPE_END;
        end else begin
            n_evsize = n_fsize;
            n_recv   = n_mark;
            n_comp   = n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_cmd_code;
            r_slot <= i_task_slot;
            r_ctrl <= i_is_control;
            r_type <= i_pkt_type;
            r_seq  <= i_seq_num;
            r_off  <= i_data_offset;
            r_len  <= i_payload_bytes;
            r_fsz  <= i_pkt_file_size;
        end
        if (i_cmd.read) begin
            r_t_fsize <= m_fsize[w_idx];
            r_t_mark  <= m_mark[w_idx];
            r_t_prev  <= m_prev[w_idx];
            r_t_pkts  <= m_pkts[w_idx];
            r_t_bytes <= m_bytes[w_idx];
            r_t_dup   <= m_dup[w_idx];
            r_t_late  <= m_late[w_idx];
            r_t_done  <= r_done_f[w_idx];
            r_t_seen  <= r_seen[w_idx];
            r_t_act   <= r_active[w_idx];
        end
        if (i_cmd.update) begin
            r_deliv  <= w_event;
            r_evsize <= n_evsize;
            r_recv   <= n_recv;
            r_comp   <= n_comp;
            r_pcnt   <= r_ctrl ? '0 : n_pkts;
            r_bcnt   <= r_ctrl ? '0 : n_bytes;
            r_dcnt   <= r_ctrl ? '0 : n_dup;
            r_lcnt   <= r_ctrl ? '0 : n_late;
        end
        // registering a fresh slot or removing one zeroes its row
        if (i_cmd.update && w_inrange &&
            ((r_cmd == CMD_REG && !r_t_act) || r_cmd == CMD_REMOVE)) begin
            m_fsize[w_idx] <= '0;
            m_mark[w_idx]  <= '0;
            m_prev[w_idx]  <= '0;
            m_pkts[w_idx]  <= '0;
            m_bytes[w_idx] <= '0;
            m_dup[w_idx]   <= '0;
            m_late[w_idx]  <= '0;
        end else if (i_cmd.update && w_event && !r_ctrl) begin
            m_fsize[w_idx] <= n_fsize;
            m_mark[w_idx]  <= n_mark;
            m_prev[w_idx]  <= r_seq;
            m_pkts[w_idx]  <= n_pkts;
            m_bytes[w_idx] <= n_bytes;
            m_dup[w_idx]   <= n_dup;
            m_late[w_idx]  <= n_late;
        end
        if (i_cmd.out_load) begin
            o_delivered          <= r_deliv;
            o_event_type         <= r_deliv ? r_type : '0;
            o_event_file_size    <= r_deliv ? r_evsize : '0;
            o_received_bytes     <= r_deliv ? r_recv : '0;
            o_completed          <= r_deliv & r_comp;
            o_progress           <= !r_deliv ? '0 :
                                    (r_evsize == '0) ? ((r_type == TYPE_END) ? ONE_Q16 : '0) :
                                    w_quot;
            o_event_offset       <= r_deliv ? r_off : '0;
            o_event_seq          <= r_deliv ? r_seq : '0;
            o_packet_count       <= r_deliv ? r_pcnt : '0;
            o_byte_count         <= r_deliv ? r_bcnt : '0;
            o_duplicate_count    <= r_deliv ? r_dcnt : '0;
            o_out_of_order_count <= r_deliv ? r_lcnt : '0;
        end
    end

    // per-slot flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_done_f <= '0;
            r_seen   <= '0;
        end else if (i_cmd.update && w_inrange) begin
            if (r_cmd == CMD_REG && !r_t_act) begin
                r_active[w_idx] <= 1'b1;
                r_done_f[w_idx] <= 1'b0;
                r_seen[w_idx]   <= 1'b0;
            end else if (r_cmd == CMD_REMOVE) begin
                r_active[w_idx] <= 1'b0;
                r_done_f[w_idx] <= 1'b0;
                r_seen[w_idx]   <= 1'b0;
            end else if (w_event && !r_ctrl) begin
                r_done_f[w_idx] <= n_done;
                r_seen[w_idx]   <= 1'b1;
            end
        end
    end

    ftpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_recv),
        .i_den   (n_evsize),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    logic r_need;
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_need <= w_event && n_evsize != '0;
        end
    end

    assign o_status.need_div = r_need;
    assign o_status.div_done = w_div_done;

`ifndef SYNTHESIS
    a_remove_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && w_inrange && r_cmd == CMD_REMOVE) |=> !r_active[$past(w_idx)])
        else $error("remove left slot active");
    a_register_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && w_inrange && r_cmd == CMD_REG) |=> r_active[$past(w_idx)])
        else $error("register did not activate");
    a_progress_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_need) |-> w_quot <= ONE_Q16) else $error("progress above one");
`endif

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
    import ftpt_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [2:0] TYPE_STATUS = 3'd0;
    localparam logic [2:0] TYPE_OTHER  = 3'd4;
    localparam int         RAND_ITEMS  = 1550;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  slot;
        logic        ctrl;
        logic [2:0]  ptype;
        logic [31:0] seq;
        logic [47:0] off;
        logic [15:0] len;
        logic [47:0] fsz;
    } pkt_t;

    typedef struct packed {
        logic        delivered;
        logic [2:0]  etype;
        logic [47:0] fsize;
        logic [47:0] recv;
        logic        done;
        logic [16:0] prog;
        logic [47:0] off;
        logic [31:0] seq;
        logic [31:0] pkts;
        logic [47:0] bytes;
        logic [31:0] dups;
        logic [31:0] lates;
    } event_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0]  i_cmd = '0;
    logic [3:0]  i_task_slot = '0;
    logic        i_is_control = 1'b0;
    logic [2:0]  i_pkt_type = '0;
    logic [31:0] i_seq_num = '0;
    logic [47:0] i_data_offset = '0;
    logic [15:0] i_payload_bytes = '0;
    logic [47:0] i_pkt_file_size = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_delivered;
    logic [2:0]  o_event_type;
    logic [47:0] o_event_file_size;
    logic [47:0] o_received_bytes;
    logic        o_completed;
    logic [16:0] o_progress;
    logic [47:0] o_event_offset;
    logic [31:0] o_event_seq;
    logic [31:0] o_packet_count;
    logic [47:0] o_byte_count;
    logic [31:0] o_duplicate_count;
    logic [31:0] o_out_of_order_count;

    file_transfer_progress_tracker dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // tracker mirror
    logic        act_tbl   [16];
    logic [47:0] size_tbl  [16];
    logic [47:0] mark_tbl  [16];
    logic        done_tbl  [16];
    logic        seen_tbl  [16];
    logic [31:0] prev_tbl  [16];
    logic [31:0] pkts_tbl  [16];
    logic [47:0] bytes_tbl [16];
    logic [31:0] dup_tbl   [16];
    logic [31:0] late_tbl  [16];

    event_t expected_events[$];
    pkt_t   stim_pkts[$];
    bit     stim_zero[$];
    logic   cur_zero = 1'b0;
    int     errors = 0;
    int     accepted = 0;
    bit     hold_done = 1'b0;

    function automatic void wipe_slot(int s);
        size_tbl[s] = '0; mark_tbl[s] = '0; done_tbl[s] = 1'b0; seen_tbl[s] = 1'b0;
        prev_tbl[s] = '0; pkts_tbl[s] = '0; bytes_tbl[s] = '0;
        dup_tbl[s] = '0; late_tbl[s] = '0;
    endfunction

    function automatic logic [47:0] payload_end(logic [47:0] off, logic [15:0] len);
        logic [48:0] e;
        e = {1'b0, off} + len;
        return e[48] ? MAX48 : e[47:0];
    endfunction

    function automatic logic [16:0] fraction_q16(logic [47:0] recv, logic [47:0] size,
                                                 logic [2:0] ptype);
        logic [63:0] q;
        if (size == '0) return (ptype == TYPE_END) ? ONE_Q16 : 17'd0;
        q = {recv, 16'h0} / {16'h0, size};
        return (q > 64'h10000) ? ONE_Q16 : q[16:0];
    endfunction

    function automatic event_t track_packet(pkt_t p);
        event_t ev;
        int s;
        logic [47:0] e;
        ev = '0;
        s = p.slot;
        if (p.cmd == CMD_REG) begin
            if (!act_tbl[s]) begin
                wipe_slot(s);
                act_tbl[s] = 1'b1;
            end
            return ev;
        end
        if (p.cmd == CMD_REMOVE) begin
            act_tbl[s] = 1'b0;
            wipe_slot(s);
            return ev;
        end
        if (p.cmd != CMD_PACKET || !act_tbl[s]) return ev;
        if (p.ctrl) begin
            ev.fsize = p.fsz;
            ev.recv  = payload_end(p.off, p.len);
            ev.done  = (p.ptype == TYPE_END);
        end else begin
            pkts_tbl[s]  = pkts_tbl[s] + 1;
            bytes_tbl[s] = bytes_tbl[s] + p.len;
            if (p.fsz != '0) size_tbl[s] = p.fsz;
            if (p.ptype == TYPE_INFO) begin
                mark_tbl[s] = '0; done_tbl[s] = 1'b0; seen_tbl[s] = 1'b0;
            end else if (p.ptype == TYPE_CHUNK || p.ptype == TYPE_END) begin
                e = payload_end(p.off, p.len);
                if (e > mark_tbl[s]) mark_tbl[s] = e;
                if (p.ptype == TYPE_END) begin
                    if (size_tbl[s] != '0) mark_tbl[s] = size_tbl[s];
                    done_tbl[s] = 1'b1;
                end
            end
            if (seen_tbl[s]) begin
                if (p.seq == prev_tbl[s]) dup_tbl[s] = dup_tbl[s] + 1;
                else if (p.seq < prev_tbl[s]) late_tbl[s] = late_tbl[s] + 1;
            end
            prev_tbl[s] = p.seq;
            seen_tbl[s] = 1'b1;
            ev.fsize = (p.fsz != '0) ? p.fsz : size_tbl[s];
            ev.recv  = mark_tbl[s];
            ev.done  = done_tbl[s];
            ev.pkts  = pkts_tbl[s];
            ev.bytes = bytes_tbl[s];
            ev.dups  = dup_tbl[s];
            ev.lates = late_tbl[s];
        end
        ev.delivered = 1'b1;
        ev.etype = p.ptype;
        ev.prog  = fraction_q16(ev.recv, ev.fsize, p.ptype);
        ev.off   = p.off;
        ev.seq   = p.seq;
        return ev;
    endfunction

    task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, got_v);
        end
    endtask

    task automatic check_event(event_t x);
        cmp_field("delivered", x.delivered, o_delivered);
        cmp_field("event_type", x.etype, o_event_type);
        cmp_field("event_file_size", x.fsize, o_event_file_size);
        cmp_field("received_bytes", x.recv, o_received_bytes);
        cmp_field("completed", x.done, o_completed);
        cmp_field("progress", x.prog, o_progress);
        cmp_field("event_offset", x.off, o_event_offset);
        cmp_field("event_seq", x.seq, o_event_seq);
        cmp_field("packet_count", x.pkts, o_packet_count);
        cmp_field("byte_count", x.bytes, o_byte_count);
        cmp_field("duplicate_count", x.dups, o_duplicate_count);
        cmp_field("out_of_order_count", x.lates, o_out_of_order_count);
    endtask

    // beat monitor on both channels
    always @(posedge i_clk) begin
        event_t ev;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_events.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result beat, delivered %0h", $realtime,
                             o_delivered);
                end else begin
                    check_event(expected_events.pop_front());
                end
            end
            if (i_valid && o_ready) begin
                ev = track_packet({i_cmd, i_task_slot, i_is_control, i_pkt_type,
                                   i_seq_num, i_data_offset, i_payload_bytes,
                                   i_pkt_file_size});
                // no-event rows carry a hand-written all-zero result
                if (cur_zero) ev = '0;
                expected_events.push_back(ev);
                accepted++;
            end
        end
    end

    function automatic pkt_t mk(logic [1:0] cmd, logic [3:0] slot, logic ctrl,
                                logic [2:0] ptype, logic [31:0] seq, logic [47:0] off,
                                logic [15:0] len, logic [47:0] fsz);
        pkt_t p;
        p = {cmd, slot, ctrl, ptype, seq, off, len, fsz};
        return p;
    endfunction

    function automatic logic [47:0] rand48();
        return {$urandom, $urandom} & MAX48;
    endfunction

    task automatic add(pkt_t p, bit zero);
        stim_pkts.push_back(p);
        stim_zero.push_back(zero);
    endtask

    task automatic build_directed();
        add(mk(CMD_PACKET, 0, 0, TYPE_CHUNK, 1, 0, 10, 0), 1);
        add(mk(CMD_REG, 0, 0, TYPE_STATUS, 0, 0, 0, 0), 1);
        add(mk(CMD_REG, 15, 0, TYPE_STATUS, 0, 0, 0, 0), 1);
        add(mk(CMD_UNUSED, 0, 0, TYPE_CHUNK, 3, 4, 5, 6), 1);
        add(mk(CMD_PACKET, 0, 0, TYPE_INFO, 5, 0, 0, 1000), 0);
        add(mk(CMD_PACKET, 0, 0, TYPE_CHUNK, 6, 0, 500, 0), 0);
        add(mk(CMD_PACKET, 0, 0, TYPE_CHUNK, 6, 500, 100, 0), 0);
        add(mk(CMD_PACKET, 0, 0, TYPE_CHUNK, 3, 600, 0, 0), 0);
        add(mk(CMD_PACKET, 0, 0, TYPE_STATUS, 32'hFFFF_FFFF, 0, 16'hFFFF, 0), 0);
        add(mk(CMD_PACKET, 0, 0, TYPE_CHUNK, 7, MAX48, 16'hFFFF, 0), 0);
        add(mk(CMD_PACKET, 0, 0, TYPE_OTHER, 8, 1, 1, MAX48), 0);
        add(mk(CMD_PACKET, 0, 0, 3'd7, 9, 2, 2, 0), 0);
        add(mk(CMD_PACKET, 0, 0, TYPE_END, 10, 0, 0, 0), 0);
        add(mk(CMD_PACKET, 15, 0, TYPE_END, 0, 100, 1, 0), 0);
        add(mk(CMD_PACKET, 15, 1, TYPE_END, 1, MAX48, 16'hFFFF, 0), 0);
        add(mk(CMD_PACKET, 15, 1, TYPE_CHUNK, 2, 10, 20, 100), 0);
        add(mk(CMD_PACKET, 15, 1, TYPE_STATUS, 3, 10, 0, 0), 0);
        add(mk(CMD_REG, 0, 0, TYPE_STATUS, 0, 0, 0, 0), 1);
        add(mk(CMD_PACKET, 0, 0, TYPE_CHUNK, 11, 0, 1, 1), 0);
        add(mk(CMD_REMOVE, 0, 0, TYPE_STATUS, 0, 0, 0, 0), 1);
        add(mk(CMD_PACKET, 0, 0, TYPE_CHUNK, 12, 0, 1, 0), 1);
        add(mk(CMD_REG, 0, 0, TYPE_STATUS, 0, 0, 0, 0), 1);
        add(mk(CMD_PACKET, 0, 0, TYPE_CHUNK, 0, 0, 0, 0), 0);
    endtask

    // mostly complete transfers with random content, some noise
    task automatic build_random();
        logic [3:0]  slot;
        logic [47:0] fsz, off;
        logic [31:0] seq;
        logic [15:0] len;
        int n, k;
        while (stim_pkts.size() < RAND_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                slot = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
                k = $urandom_range(0, 3);
                fsz = (k == 0) ? 48'd0 : (k == 1) ? rand48() : 48'($urandom_range(1, 200000));
                seq = $urandom;
                off = (k == 1) ? rand48() : 48'd0;
                if ($urandom_range(0, 2) != 0)
                    add(mk(CMD_REG, slot, 0, TYPE_STATUS, 0, 0, 0, 0), 0);
                add(mk(CMD_PACKET, slot, 0, TYPE_INFO, seq, 0, 0, fsz), 0);
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    len = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                          16'($urandom_range(0, 4000));
                    k = $urandom_range(0, 9);
                    if (k == 0) seq = seq - $urandom_range(1, 5);
                    else if (k != 1) seq = seq + 1;
                    add(mk(CMD_PACKET, slot, $urandom_range(0, 9) == 0,
                           ($urandom_range(0, 7) == 0) ? 3'($urandom) : TYPE_CHUNK,
                           seq, off, len, ($urandom_range(0, 3) == 0) ? fsz : 48'd0), 0);
                    off = off + len;
                end
                if ($urandom_range(0, 3) != 0)
                    add(mk(CMD_PACKET, slot, 0, TYPE_END, seq + 1, off, 0,
                           ($urandom_range(0, 1) == 0) ? fsz : 48'd0), 0);
                if ($urandom_range(0, 4) == 0)
                    add(mk(CMD_REMOVE, slot, 0, TYPE_STATUS, 0, 0, 0, 0), 0);
            end else begin
                add(mk(2'($urandom), 4'($urandom), 1'($urandom), 3'($urandom), $urandom,
                       rand48(), 16'($urandom), rand48()), 0);
            end
        end
    endtask

    // sender: bursts and gaps
    initial begin
        int burst, gap;
        pkt_t p;
        build_directed();
        build_random();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (stim_pkts.size() != 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && stim_pkts.size() != 0) begin
                p = stim_pkts.pop_front();
                cur_zero <= stim_zero.pop_front();
                i_valid <= 1'b1;
                {i_cmd, i_task_slot, i_is_control, i_pkt_type, i_seq_num, i_data_offset,
                 i_payload_bytes, i_pkt_file_size} <= p;
                do @(posedge i_clk); while (!o_ready);
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (errors == 0)
            $display("[file_transfer_progress_tracker] OK");
        else
            $display("[file_transfer_progress_tracker] ERROR");
        $finish;
    end

    // receiver: stall modes that change every stretch, one long hold-off
    initial begin
        int mode, span, hold;
        mode = 0;
        span = 0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && accepted >= 300) begin
                i_ready <= 1'b0;
                hold = 0;
                while (hold < 600) begin
                    @(posedge i_clk);
                    hold++;
                end
                hold_done = 1'b1;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 300);
            end
            span--;
            case (mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 1) == 0);
                2: i_ready <= ($urandom_range(0, 9) == 0);
                default: i_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    initial begin
        #4000000;
        $display("[file_transfer_progress_tracker] ERROR");
        $finish;
    end

endmodule
